[rtl/fcot_pkg.sv]
package fcot_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int NOW_W   = 48;
    localparam int DUR_W   = 32;
    localparam int TAG_W   = 8;
    localparam int KIND_W  = 2;
    localparam int FPS_W   = 16;
    localparam int TOTAL_W = 32;

    localparam logic [NOW_W-1:0] MS_PER_SECOND = 48'd1000;

    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ADD_OK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD_FULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FIRED    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SUMMARY  = 2'd3;

    typedef struct packed {
        logic [DUR_W-1:0] duration;
        logic [NOW_W-1:0] start;
        logic [TAG_W-1:0] tag;
    } t_entry;

    typedef struct packed {
        logic start_add;
        logic start_tick;
        logic acc;
        logic rd_scan;
        logic fire;
        logic scan_next;
        logic cmp_init;
        logic cmp_rd;
        logic cmp_wr;
        logic cmp_end;
        logic load_add;
        logic load_sum;
    } t_cmd;

    typedef struct packed {
        logic scan_empty;
        logic scan_one;
        logic hit;
        logic any_fired;
        logic cmp_last;
        logic out_free;
    } t_status;

endpackage

[rtl/fcot_if.sv]
interface fcot_req_if import fcot_pkg::*;;
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [NOW_W-1:0] now_ms;
    logic [DUR_W-1:0] duration_ms;
    logic [TAG_W-1:0] timer_tag;

    modport source (output valid, output req_type, output now_ms, output duration_ms,
                    output timer_tag, input ready);
    modport sink (input valid, input req_type, input now_ms, input duration_ms,
                  input timer_tag, output ready);
endinterface

interface fcot_res_if import fcot_pkg::*;;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  result_kind;
    logic [TAG_W-1:0]   fired_tag;
    logic [NOW_W-1:0]   step_ms;
    logic [FPS_W-1:0]   frames_per_second;
    logic [TOTAL_W-1:0] total_frames;
    logic               last;

    modport source (output valid, output result_kind, output fired_tag, output step_ms,
                    output frames_per_second, output total_frames, output last,
                    input ready);
    modport sink (input valid, input result_kind, input fired_tag, input step_ms,
                  input frames_per_second, input total_frames, input last,
                  output ready);
endinterface

[rtl/fcot_datapath.sv]
module fcot_datapath import fcot_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_sts,
    input  logic [NOW_W-1:0]  i_now_ms,
    input  logic [DUR_W-1:0]  i_duration_ms,
    input  logic [TAG_W-1:0]  i_timer_tag,
    fcot_res_if.source        o_res
);

    localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    t_entry r_mem [TIMER_SLOTS];
    t_entry r_rdata;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_scan;
    logic [CW-1:0]          r_rd;
    logic [CW-1:0]          r_wr;
    logic [TIMER_SLOTS-1:0] r_fired;

    logic [NOW_W-1:0]   r_now;
    logic [DUR_W-1:0]   r_dur;
    logic [TAG_W-1:0]   r_tag;
    logic [NOW_W-1:0]   r_last_time;
    logic [NOW_W-1:0]   r_step;
    logic [NOW_W-1:0]   r_acc;
    logic [TOTAL_W-1:0] r_frames;
    logic [FPS_W-1:0]   r_rate;
    logic [TOTAL_W-1:0] r_total;

    logic               r_out_valid;
    logic [KIND_W-1:0]  r_kind;
    logic [TAG_W-1:0]   r_out_tag;
    logic [NOW_W-1:0]   r_out_step;
    logic [FPS_W-1:0]   r_out_fps;
    logic [TOTAL_W-1:0] r_out_total;
    logic               r_out_last;

    logic [CW-1:0]    scan_pos;
    logic [IW-1:0]    scan_idx;
    logic [IW-1:0]    rd_idx;
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W:0]   acc_sum;
    logic [NOW_W-1:0] acc_sat;
    logic [CW:0]      rd_plus;
    logic             table_full;

    assign scan_pos   = r_scan - CW'(1);
    assign scan_idx   = scan_pos[IW-1:0];
    assign rd_idx     = r_rd[IW-1:0];
    assign elapsed    = r_now - r_rdata.start;
    assign acc_sum    = {1'b0, r_acc} + {1'b0, r_step};
    assign acc_sat    = acc_sum[NOW_W] ? {NOW_W{1'b1}} : acc_sum[NOW_W-1:0];
    assign rd_plus    = {1'b0, r_rd} + (CW+1)'(1);
    assign table_full = (r_count == CW'(TIMER_SLOTS));

    assign o_sts.scan_empty = (r_scan == '0);
    assign o_sts.scan_one   = (r_scan == CW'(1));
    assign o_sts.hit        = (elapsed >= {{(NOW_W-DUR_W){1'b0}}, r_rdata.duration});
    assign o_sts.any_fired  = |r_fired;
    assign o_sts.cmp_last   = (rd_plus == {1'b0, r_count});
    assign o_sts.out_free   = !r_out_valid || o_res.ready;

    assign o_res.valid             = r_out_valid;
    assign o_res.result_kind       = r_kind;
    assign o_res.fired_tag         = r_out_tag;
    assign o_res.step_ms           = r_out_step;
    assign o_res.frames_per_second = r_out_fps;
    assign o_res.total_frames      = r_out_total;
    assign o_res.last              = r_out_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_add && !table_full) begin
            r_mem[r_count[IW-1:0]] <= '{duration: r_dur, start: r_now, tag: r_tag};
        end else if (i_cmd.cmp_wr && !r_fired[rd_idx]) begin
            r_mem[r_wr[IW-1:0]] <= r_rdata;
        end
        if (i_cmd.rd_scan) begin
            r_rdata <= r_mem[scan_idx];
        end else if (i_cmd.cmp_rd) begin
            r_rdata <= r_mem[rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_add || i_cmd.start_tick) begin
            r_now <= i_now_ms;
            r_dur <= i_duration_ms;
            r_tag <= i_timer_tag;
        end
        if (i_cmd.start_tick) begin
            r_step <= i_now_ms - r_last_time;
        end
        if (i_cmd.load_add) begin
            r_kind      <= table_full ? KIND_ADD_FULL : KIND_ADD_OK;
            r_out_tag   <= r_tag;
            r_out_step  <= '0;
            r_out_fps   <= '0;
            r_out_total <= '0;
            r_out_last  <= 1'b1;
        end else if (i_cmd.fire) begin
            r_kind      <= KIND_FIRED;
            r_out_tag   <= r_rdata.tag;
            r_out_step  <= '0;
            r_out_fps   <= '0;
            r_out_total <= '0;
            r_out_last  <= 1'b0;
        end else if (i_cmd.load_sum) begin
            r_kind      <= KIND_SUMMARY;
            r_out_tag   <= '0;
            r_out_step  <= r_step;
            r_out_fps   <= r_rate;
            r_out_total <= r_total;
            r_out_last  <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_scan      <= '0;
            r_rd        <= '0;
            r_wr        <= '0;
            r_fired     <= '0;
            r_last_time <= '0;
            r_acc       <= '0;
            r_frames    <= '0;
            r_rate      <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_add || i_cmd.fire || i_cmd.load_sum) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.load_add && !table_full) begin
                r_count <= r_count + CW'(1);
            end

            if (i_cmd.start_tick) begin
                r_last_time <= i_now_ms;
                r_total     <= r_total + TOTAL_W'(1);
                if (r_frames != {TOTAL_W{1'b1}}) begin
                    r_frames <= r_frames + TOTAL_W'(1);
                end
                r_fired <= '0;
                r_scan  <= r_count;
            end

            if (i_cmd.acc) begin
                if (acc_sat >= MS_PER_SECOND) begin
                    r_rate   <= (|r_frames[TOTAL_W-1:FPS_W]) ? {FPS_W{1'b1}}
                                                             : r_frames[FPS_W-1:0];
                    r_frames <= '0;
                    r_acc    <= '0;
                end else begin
                    r_acc <= acc_sat;
                end
            end

            if (i_cmd.fire) begin
                r_fired[scan_idx] <= 1'b1;
            end
            if (i_cmd.scan_next) begin
                r_scan <= scan_pos;
            end

            if (i_cmd.cmp_init) begin
                r_rd <= '0;
                r_wr <= '0;
            end
            if (i_cmd.cmp_wr) begin
                r_rd <= r_rd + CW'(1);
                if (!r_fired[rd_idx]) begin
                    r_wr <= r_wr + CW'(1);
                end
            end
            if (i_cmd.cmp_end) begin
                r_count <= r_wr;
            end
        end
    end

endmodule

[rtl/fcot_ctrl.sv]
module fcot_ctrl import fcot_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    fcot_req_if.sink i_req,
    input  t_status i_sts,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_ACC,
        S_RD,
        S_CHK,
        S_CSEL,
        S_CRD,
        S_CWR,
        S_CEND,
        S_SUM
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    assign i_req.ready = (r_state == S_IDLE);
    assign o_cmd       = cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_ADD) begin
                        cmd.start_add = 1'b1;
                        n_state       = S_ADD;
                    end else begin
                        cmd.start_tick = 1'b1;
                        n_state        = S_ACC;
                    end
                end
            end
            S_ADD: begin
                if (i_sts.out_free) begin
                    cmd.load_add = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_ACC: begin
                cmd.acc = 1'b1;
                n_state = i_sts.scan_empty ? S_SUM : S_RD;
            end
            S_RD: begin
                cmd.rd_scan = 1'b1;
                n_state     = S_CHK;
            end
            S_CHK: begin
                if (!i_sts.hit || i_sts.out_free) begin
                    cmd.fire      = i_sts.hit;
                    cmd.scan_next = 1'b1;
                    n_state       = i_sts.scan_one ? S_CSEL : S_RD;
                end
            end
            S_CSEL: begin
                if (i_sts.any_fired) begin
                    cmd.cmp_init = 1'b1;
                    n_state      = S_CRD;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_CRD: begin
                cmd.cmp_rd = 1'b1;
                n_state    = S_CWR;
            end
            S_CWR: begin
                cmd.cmp_wr = 1'b1;
                n_state    = i_sts.cmp_last ? S_CEND : S_CRD;
            end
            S_CEND: begin
                cmd.cmp_end = 1'b1;
                n_state     = S_SUM;
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    cmd.load_sum = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/frame_clock_with_oneshot_timers_unit.sv]
// Frame clock with a table of TIMER_SLOTS one-shot timers held in a single-port
// memory. An add is accepted, then the acknowledge (or table-full reject) is loaded
// into the output register. A frame tick does one memory read and one elapsed-time
// compare per stored timer, highest index first; when at least one timer fires, it
// then compacts the table through the same memory port, and it ends with the frame
// summary. Stalls on the result channel hold the add, each fired timer and the summary;
// the next item is taken while the last result waits.
module frame_clock_with_oneshot_timers_unit import fcot_pkg::*; #(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fcot_req_if.sink   i_req,
    fcot_res_if.source o_res
);

    t_cmd    cmd;
    t_status sts;

    fcot_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    fcot_datapath #(
        .TIMER_SLOTS (TIMER_SLOTS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_now_ms      (i_req.now_ms),
        .i_duration_ms (i_req.duration_ms),
        .i_timer_tag   (i_req.timer_tag),
        .o_res         (o_res)
    );

endmodule

[verif/frame_clock_with_oneshot_timers_unit_tb.sv]
module frame_clock_with_oneshot_timers_unit_tb;
    import fcot_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 470;
    localparam int CALM_TAIL    = 50;
    localparam int DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag;
        logic [NOW_W-1:0]   step_ms;
        logic [FPS_W-1:0]   fps;
        logic [TOTAL_W-1:0] total;
        logic               last;
    } t_outcome;

    class frame_clock_tracker;
        logic [NOW_W-1:0]   last_tick_ms;
        logic [NOW_W-1:0]   second_ms;
        logic [TOTAL_W-1:0] frames_in_second;
        logic [FPS_W-1:0]   rate;
        logic [TOTAL_W-1:0] ticks;
        t_entry             timers[$];
        t_outcome           pending_results[$];
        int                 errors;
        int                 checked;

        function new();
            last_tick_ms     = '0;
            second_ms        = '0;
            frames_in_second = '0;
            rate             = '0;
            ticks            = '0;
            errors           = 0;
            checked          = 0;
        endfunction

        function void push_result(logic [KIND_W-1:0] kind, logic [TAG_W-1:0] tag,
                                  logic [NOW_W-1:0] step_ms, logic [FPS_W-1:0] fps,
                                  logic [TOTAL_W-1:0] total, logic last);
            t_outcome r;
            r.kind    = kind;
            r.tag     = tag;
            r.step_ms = step_ms;
            r.fps     = fps;
            r.total   = total;
            r.last    = last;
            pending_results = {pending_results, r};
        endfunction

        function void take_request(logic req, logic [NOW_W-1:0] now_ms,
                                   logic [DUR_W-1:0] dur_ms, logic [TAG_W-1:0] tag);
            t_entry           e;
            logic [NOW_W-1:0] step_ms;
            logic [NOW_W:0]   sum;
            logic [NOW_W-1:0] elapsed;
            if (req == REQ_ADD) begin
                if (timers.size() < TIMER_SLOTS_DEF) begin
                    e.duration = dur_ms;
                    e.start    = now_ms;
                    e.tag      = tag;
                    timers     = {timers, e};
                    push_result(KIND_ADD_OK, tag, '0, '0, '0, 1'b1);
                end else begin
                    push_result(KIND_ADD_FULL, tag, '0, '0, '0, 1'b1);
                end
                return;
            end
            step_ms      = now_ms - last_tick_ms;
            last_tick_ms = now_ms;
            ticks        = ticks + 1'b1;
            if (frames_in_second != '1)
                frames_in_second = frames_in_second + 1'b1;
            sum       = {1'b0, second_ms} + {1'b0, step_ms};
            second_ms = sum[NOW_W] ? '1 : sum[NOW_W-1:0];
            if (second_ms >= MS_PER_SECOND) begin
                rate = (frames_in_second > 32'hFFFF) ? 16'hFFFF : frames_in_second[FPS_W-1:0];
                frames_in_second = '0;
                second_ms        = '0;
            end
            for (int i = timers.size() - 1; i >= 0; i--) begin
                elapsed = now_ms - timers[i].start;
                if (elapsed >= {{(NOW_W-DUR_W){1'b0}}, timers[i].duration}) begin
                    push_result(KIND_FIRED, timers[i].tag, '0, '0, '0, 1'b0);
                    timers.delete(i);
                end
            end
            push_result(KIND_SUMMARY, '0, step_ms, rate, ticks, 1'b1);
        endfunction

        task report(string field, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("result %0d: %s got %0h expected %0h", checked, field, got, want);
        endtask

        task match_result(t_outcome got);
            t_outcome want;
            checked++;
            if (pending_results.size() == 0) begin
                report("unexpected transfer, kind", got.kind, '0);
                return;
            end
            want = pending_results.pop_front();
            if (got.kind !== want.kind)       report("result_kind", got.kind, want.kind);
            if (got.tag !== want.tag)         report("fired_tag", got.tag, want.tag);
            if (got.step_ms !== want.step_ms) report("step_ms", got.step_ms, want.step_ms);
            if (got.fps !== want.fps)         report("frames_per_second", got.fps, want.fps);
            if (got.total !== want.total)     report("total_frames", got.total, want.total);
            if (got.last !== want.last)       report("last", got.last, want.last);
        endtask

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_count;
    int   idle_pct;
    int   add_pct;
    int   stall_left;

    fcot_req_if req_if();
    fcot_res_if res_if();

    frame_clock_tracker tracker;

    frame_clock_with_oneshot_timers_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("frame_clock_with_oneshot_timers_unit: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 5);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_outcome got;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready)
                tracker.take_request(req_if.req_type, req_if.now_ms, req_if.duration_ms,
                                     req_if.timer_tag);
            if (res_if.valid && res_if.ready) begin
                got.kind    = res_if.result_kind;
                got.tag     = res_if.fired_tag;
                got.step_ms = res_if.step_ms;
                got.fps     = res_if.frames_per_second;
                got.total   = res_if.total_frames;
                got.last    = res_if.last;
                tracker.match_result(got);
            end
        end
    end

    task send_request(logic req, logic [NOW_W-1:0] now_ms, logic [DUR_W-1:0] dur_ms,
                      logic [TAG_W-1:0] tag);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.req_type    <= req;
        req_if.now_ms      <= now_ms;
        req_if.duration_ms <= dur_ms;
        req_if.timer_tag   <= tag;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task run_directed();
        // first tick measures from time zero
        send_request(REQ_TICK, 48'd0, 32'd0, 8'd0);
        send_request(REQ_ADD, 48'd5, 32'd0, 8'h00);
        send_request(REQ_ADD, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_TICK, 48'd10, 32'hFFFF_FFFF, 8'hFF);
        // fill the table, then overflow it
        for (int i = 1; i <= 15; i++)
            send_request(REQ_ADD, 48'd20, 32'(i * 3), 8'(i * 17));
        send_request(REQ_ADD, 48'd21, 32'h5555_AAAA, 8'hA5);
        // many timers expire on one tick
        send_request(REQ_TICK, 48'd1200, 32'd0, 8'd0);
        send_request(REQ_TICK, 48'd1700, 32'd0, 8'd0);
        // time steps back: step wraps and the accumulator saturates
        send_request(REQ_TICK, 48'd1699, 32'd0, 8'd0);
        send_request(REQ_TICK, 48'h8000_0000_0000, 32'd0, 8'd0);
    endtask

    task run_random();
        logic [NOW_W-1:0] clock_ms;
        logic [NOW_W-1:0] now_ms;
        logic [DUR_W-1:0] dur_ms;
        logic [63:0]      wide;
        int               pick;
        clock_ms = 48'h8000_0000_0000;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
                add_pct = $urandom_range(30, 75);
            end
            if (n >= RANDOM_ITEMS - CALM_TAIL)
                idle_pct = 0;
            pick = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < add_pct) begin
                clock_ms = clock_ms + $urandom_range(0, 20);
                now_ms   = clock_ms;
                if (pick < 5) begin
                    wide   = {$urandom(), $urandom()};
                    now_ms = wide[NOW_W-1:0];
                end
                if (pick < 70)
                    dur_ms = $urandom_range(0, 400);
                else if (pick < 85)
                    dur_ms = $urandom_range(0, 5);
                else
                    dur_ms = $urandom();
                send_request(REQ_ADD, now_ms, dur_ms, TAG_W'($urandom_range(0, 255)));
            end else begin
                if (pick < 4) begin
                    wide     = {$urandom(), $urandom()};
                    clock_ms = wide[NOW_W-1:0];
                end else if (pick < 7) begin
                    clock_ms = clock_ms - $urandom_range(1, 100);
                end else begin
                    clock_ms = clock_ms + $urandom_range(0, 250);
                end
                send_request(REQ_TICK, clock_ms, $urandom(), TAG_W'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cycle_count        = 0;
        idle_pct           = 0;
        add_pct            = 50;
        stall_left         = 0;
        req_if.valid       = 1'b0;
        req_if.req_type    = REQ_ADD;
        req_if.now_ms      = '0;
        req_if.duration_ms = '0;
        req_if.timer_tag   = '0;
        res_if.ready       = 1'b0;
        tracker            = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        idle_pct = 20;
        run_directed();
        run_random();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("frame_clock_with_oneshot_timers_unit: match");
        else
            $display("frame_clock_with_oneshot_timers_unit: mismatch");
        $finish;
    end

endmodule

[sim.f]
rtl/fcot_pkg.sv
rtl/fcot_if.sv
rtl/fcot_datapath.sv
rtl/fcot_ctrl.sv
rtl/frame_clock_with_oneshot_timers_unit.sv
verif/frame_clock_with_oneshot_timers_unit_tb.sv
